@@ rtl/core/hssd_pkg.sv @@
// Shared types and constants for the half-step stepper command driver.
package hssd_pkg;

  // Characters of the serial command set
  localparam logic [7:0] CHAR_NUL    = 8'h00;
  localparam logic [7:0] CHAR_CCW    = 8'h41;  // 'A'
  localparam logic [7:0] CHAR_CW     = 8'h48;  // 'H'
  localparam logic [7:0] CHAR_STOP   = 8'h53;  // 'S'
  localparam logic [7:0] CHAR_DIGIT0 = 8'h30;  // '0'
  localparam logic [7:0] CHAR_DIGIT3 = 8'h33;  // '3'

  // Speed period registers
  localparam int unsigned NUM_SPEEDS = 4;
  localparam int unsigned SPEED_SEL_W = 2;
  localparam int unsigned PERIOD_W = 16;
  localparam int unsigned CFG_INDEX_W = 4;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_SPEED_ZERO  = 4'd0,
    REG_SPEED_ONE   = 4'd1,
    REG_SPEED_TWO   = 4'd2,
    REG_SPEED_THREE = 4'd3
  } hssd_reg_e;

  localparam logic [PERIOD_W-1:0] PERIOD_RESET [NUM_SPEEDS] = '{
    16'd1000, 16'd1428, 16'd2500, 16'd10000
  };

  // Half-step coil tables, clockwise order and its reverse
  localparam int unsigned TABLE_LEN = 8;
  localparam int unsigned TABLE_IDX_W = 3;
  localparam int unsigned COIL_W = 4;

  localparam logic [COIL_W-1:0] CW_PATTERN [TABLE_LEN] = '{
    4'h1, 4'h3, 4'h2, 4'h6, 4'h4, 4'hc, 4'h8, 4'h9
  };
  localparam logic [COIL_W-1:0] CCW_PATTERN [TABLE_LEN] = '{
    4'h9, 4'h8, 4'hc, 4'h4, 4'h6, 4'h2, 4'h3, 4'h1
  };

  // Command decode results handed to the step unit
  typedef struct packed {
    logic stop;     // 'S' command completes this word
    logic enable;   // stepping enable after this word
    logic ccw;      // direction after this word
  } hssd_cmd_t;

  // One result word
  typedef struct packed {
    logic [COIL_W-1:0] coil_pattern;
    logic              step_taken;
    logic              echo_valid;
    logic [7:0]        echo_byte;
    logic              running;
  } hssd_result_t;

endpackage

@@ rtl/core/hssd_cmd.sv @@
// Command parser: pairs received characters, holds direction, enable and speed registers.
module hssd_cmd
  import hssd_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   accept_i,
  input  logic                   operation_i,
  input  logic [7:0]             rx_byte_i,
  input  logic                   cfg_valid_i,
  input  logic [CFG_INDEX_W-1:0] cfg_index_i,
  input  logic [PERIOD_W-1:0]    cfg_data_i,
  output hssd_cmd_t              cmd_o,
  output logic [PERIOD_W-1:0]    active_period_o
);

  logic                have_first_q, have_first_d;
  logic [7:0]          first_char_q, first_char_d;
  logic                ccw_q, ccw_d;
  logic                enable_q, enable_d;
  logic [PERIOD_W-1:0] period_q, period_d;
  logic [PERIOD_W-1:0] speed_q [NUM_SPEEDS];

  logic byte_word;
  logic second_char;
  logic is_digit;

  assign byte_word   = accept_i && !operation_i && (rx_byte_i != CHAR_NUL);
  assign second_char = byte_word && have_first_q;
  assign is_digit    = (rx_byte_i >= CHAR_DIGIT0) && (rx_byte_i <= CHAR_DIGIT3);

  // Pairing and command execution
  always_comb begin
    have_first_d = have_first_q;
    first_char_d = first_char_q;
    ccw_d        = ccw_q;
    enable_d     = enable_q;
    period_d     = period_q;
    if (byte_word) begin
      if (!have_first_q) begin
        have_first_d = 1'b1;
        first_char_d = rx_byte_i;
      end else begin
        have_first_d = 1'b0;
        unique case (first_char_q)
          CHAR_CCW: begin
            ccw_d    = 1'b1;
            enable_d = 1'b1;
          end
          CHAR_CW: begin
            ccw_d    = 1'b0;
            enable_d = 1'b1;
          end
          CHAR_STOP: begin
            enable_d = 1'b0;
          end
          default: begin
          end
        endcase
        if (first_char_q != CHAR_STOP && is_digit) begin
          period_d = speed_q[rx_byte_i[SPEED_SEL_W-1:0]];
        end
      end
    end
  end

  assign cmd_o.stop      = second_char && (first_char_q == CHAR_STOP);
  assign cmd_o.enable    = enable_d;
  assign cmd_o.ccw       = ccw_d;
  assign active_period_o = period_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_first_q <= 1'b0;
      first_char_q <= CHAR_NUL;
      ccw_q        <= 1'b0;
      enable_q     <= 1'b0;
      period_q     <= '0;
    end else begin
      have_first_q <= have_first_d;
      first_char_q <= first_char_d;
      ccw_q        <= ccw_d;
      enable_q     <= enable_d;
      period_q     <= period_d;
    end
  end

  // Speed period registers, written from the configuration port
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_SPEEDS; i++) begin
        speed_q[i] <= PERIOD_RESET[i];
      end
    end else if (cfg_valid_i && cfg_index_i <= REG_SPEED_THREE) begin
      speed_q[cfg_index_i[SPEED_SEL_W-1:0]] <= cfg_data_i;
    end
  end

endmodule

@@ rtl/core/hssd_step.sv @@
// Step unit: tick counter, pending wrap, step index and coil register.
module hssd_step
  import hssd_pkg::*;
#(
  parameter int unsigned SeqLen = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                accept_i,
  input  logic                operation_i,
  input  hssd_cmd_t           cmd_i,
  input  logic [PERIOD_W-1:0] active_period_i,
  output logic [COIL_W-1:0]   coil_o,
  output logic                step_taken_o
);

  localparam int unsigned IdxW = $clog2(SeqLen);

  logic [PERIOD_W-1:0] count_q, count_d;
  logic                wrap_q, wrap_d;
  logic [IdxW-1:0]     idx_q, idx_d;
  logic [COIL_W-1:0]   coil_q, coil_d;

  logic                  wrap_set;
  logic                  wrap_mid;
  logic [IdxW-1:0]       idx_mid;
  logic                  issue;
  logic [TABLE_IDX_W-1:0] tab_idx;

  // Tick counter; a zero period halts it
  always_comb begin
    count_d  = count_q;
    wrap_set = 1'b0;
    if (accept_i && operation_i && active_period_i != '0) begin
      if (count_q == active_period_i) begin
        count_d  = '0;
        wrap_set = 1'b1;
      end else begin
        count_d = count_q + PERIOD_W'(1);
      end
    end
  end

  // Stop command clears the pending wrap and rewinds the sequence
  assign wrap_mid = cmd_i.stop ? 1'b0 : (wrap_q || wrap_set);
  assign idx_mid  = cmd_i.stop ? '0 : idx_q;
  assign issue    = accept_i && cmd_i.enable && wrap_mid;
  assign tab_idx  = TABLE_IDX_W'(idx_mid);

  // Step issue
  always_comb begin
    wrap_d = wrap_q;
    idx_d  = idx_q;
    coil_d = coil_q;
    if (accept_i) begin
      wrap_d = wrap_mid;
      idx_d  = idx_mid;
      if (issue) begin
        wrap_d = 1'b0;
        coil_d = cmd_i.ccw ? CCW_PATTERN[tab_idx] : CW_PATTERN[tab_idx];
        idx_d  = (idx_mid == IdxW'(SeqLen - 1)) ? '0 : idx_mid + IdxW'(1);
      end
    end
  end

  assign coil_o       = coil_d;
  assign step_taken_o = issue;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      wrap_q  <= 1'b0;
      idx_q   <= '0;
      coil_q  <= '0;
    end else begin
      count_q <= count_d;
      wrap_q  <= wrap_d;
      idx_q   <= idx_d;
      coil_q  <= coil_d;
    end
  end

  // A stop word leaves the sequence rewound with nothing pending
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && cmd_i.stop |=> idx_q == '0 && !wrap_q)
    else $error("step index or wrap not cleared after stop");

endmodule

@@ rtl/core/hssd_outbuf.sv @@
// Output register with a skid stage so input acceptance waits on the receiver only once the skid is full.
module hssd_outbuf
  import hssd_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  hssd_result_t data_i,
  output logic         ready_o,
  output logic         valid_o,
  input  logic         ready_i,
  output hssd_result_t data_o
);

  logic         out_valid_q, out_valid_d;
  logic         skid_valid_q, skid_valid_d;
  hssd_result_t out_q, out_d;
  hssd_result_t skid_q, skid_d;

  assign ready_o = !skid_valid_q;

  // Refill the output register from the skid stage first, then from the new word
  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_d        = out_q;
    skid_d       = skid_q;
    if (!out_valid_q || ready_i) begin
      if (skid_valid_q) begin
        out_d        = skid_q;
        out_valid_d  = 1'b1;
        skid_valid_d = 1'b0;
      end else begin
        out_d       = data_i;
        out_valid_d = push_i;
      end
    end else if (push_i) begin
      skid_d       = data_i;
      skid_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign valid_o = out_valid_q;
  assign data_o  = out_q;

  // The skid stage only fills behind a held output word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid stage full while output register empty");

endmodule

@@ rtl/core/half_step_stepper_command_driver.sv @@
// Top level of the half-step stepper command driver.
//
// Input channel (in_valid_i/in_ready_o): one word per received serial byte
// (operation_i = 0, rx_byte_i = character) or per timer tick (operation_i = 1).
// Character pairs form commands: 'H' clockwise run, 'A' counterclockwise run,
// 'S' stop; a second character '0'..'3' picks one of four speed periods.
// Configuration channel (cfg_valid_i/cfg_ready_o): writes speed period
// registers 0..3; cfg_ready_o is always high, other indexes are dropped.
// Output channel (out_valid_o/out_ready_i): exactly one result word per input
// word, in order: coil pattern, step flag, byte echo and run status.
// Results are registered at the output. Throughput is one word per
// cycle while the receiver keeps up; the whole update of counter, command and
// step state is done in the accept cycle between the input ports and the
// output register. When the receiver stalls, one more word is taken into a
// skid stage, then in_ready_o drops until the output register drains.
// Reset clears all control state, stops stepping, halts the counter and
// loads the speed registers with 1000, 1428, 2500 and 10000.
module half_step_stepper_command_driver
  import hssd_pkg::*;
#(
  parameter int unsigned SEQUENCE_LENGTH = 8
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic                   operation_i,
  input  logic [7:0]             rx_byte_i,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CFG_INDEX_W-1:0] cfg_index_i,
  input  logic [PERIOD_W-1:0]    cfg_data_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [COIL_W-1:0]      coil_pattern_o,
  output logic                   step_taken_o,
  output logic                   echo_valid_o,
  output logic [7:0]             echo_byte_o,
  output logic                   running_o
);

  logic                accept;
  hssd_cmd_t           cmd;
  logic [PERIOD_W-1:0] active_period;
  logic [COIL_W-1:0]   coil;
  logic                step_taken;
  hssd_result_t        result;
  hssd_result_t        result_out;

  assign accept      = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;

  hssd_cmd u_cmd (
    .clk_i,
    .rst_ni,
    .accept_i        (accept),
    .operation_i,
    .rx_byte_i,
    .cfg_valid_i,
    .cfg_index_i,
    .cfg_data_i,
    .cmd_o           (cmd),
    .active_period_o (active_period)
  );

  hssd_step #(
    .SeqLen (SEQUENCE_LENGTH)
  ) u_step (
    .clk_i,
    .rst_ni,
    .accept_i        (accept),
    .operation_i,
    .cmd_i           (cmd),
    .active_period_i (active_period),
    .coil_o          (coil),
    .step_taken_o    (step_taken)
  );

  // Assemble the result word
  always_comb begin
    result.coil_pattern = coil;
    result.step_taken   = step_taken;
    result.echo_valid   = !operation_i;
    result.echo_byte    = operation_i ? 8'h00 : rx_byte_i;
    result.running      = cmd.enable;
  end

  hssd_outbuf u_outbuf (
    .clk_i,
    .rst_ni,
    .push_i  (accept),
    .data_i  (result),
    .ready_o (in_ready_o),
    .valid_o (out_valid_o),
    .ready_i (out_ready_i),
    .data_o  (result_out)
  );

  assign coil_pattern_o = result_out.coil_pattern;
  assign step_taken_o   = result_out.step_taken;
  assign echo_valid_o   = result_out.echo_valid;
  assign echo_byte_o    = result_out.echo_byte;
  assign running_o      = result_out.running;

  // A step is only ever issued while running
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && step_taken_o |-> running_o)
    else $error("step issued while stopped");

endmodule

@@ sim/half_step_stepper_command_driver_tb.sv @@
// Self-checking testbench for the half-step stepper command driver.
module half_step_stepper_command_driver_tb
  import hssd_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned SEQ_LEN     = 8;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam logic        OP_BYTE     = 1'b0;
  localparam logic        OP_TICK     = 1'b1;

  typedef struct packed {
    logic       op;
    logic [7:0] data;
  } stim_word_t;

  typedef enum int {RX_ALWAYS, RX_HALF, RX_MOSTLY, RX_SPARSE, RX_PERIODIC} rx_mode_e;

  // Software copy of the stepper: command pairing, tick counter, step sequencer
  class stepper_scoreboard;
    logic [PERIOD_W-1:0] speed_period [NUM_SPEEDS];
    logic                have_first;
    logic [7:0]          first_char;
    logic                ccw;
    logic                enabled;
    logic [PERIOD_W-1:0] active_period;
    logic [PERIOD_W-1:0] tick_count;
    logic                wrap_pending;
    logic [2:0]          step_idx;
    logic [COIL_W-1:0]   coil;
    hssd_result_t        expected_q [$];
    int                  errors;

    function new();
      for (int i = 0; i < NUM_SPEEDS; i++) speed_period[i] = PERIOD_RESET[i];
      have_first    = 1'b0;
      first_char    = '0;
      ccw           = 1'b0;
      enabled       = 1'b0;
      active_period = '0;
      tick_count    = '0;
      wrap_pending  = 1'b0;
      step_idx      = '0;
      coil          = '0;
      errors        = 0;
    endfunction

    function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [PERIOD_W-1:0] data);
      // indexes past the last speed register are dropped
      if (idx <= REG_SPEED_THREE) speed_period[idx[SPEED_SEL_W-1:0]] = data;
    endfunction

    function void run_command(logic [7:0] cmd, logic [7:0] arg);
      if (cmd == CHAR_CCW) begin
        ccw     = 1'b1;
        enabled = 1'b1;
      end else if (cmd == CHAR_CW) begin
        ccw     = 1'b0;
        enabled = 1'b1;
      end else if (cmd == CHAR_STOP) begin
        enabled      = 1'b0;
        wrap_pending = 1'b0;
        step_idx     = '0;
      end
      if (cmd != CHAR_STOP && arg >= CHAR_DIGIT0 && arg <= CHAR_DIGIT3)
        active_period = speed_period[arg[SPEED_SEL_W-1:0] - CHAR_DIGIT0[SPEED_SEL_W-1:0]];
    endfunction

    // Accepted input word: update state and queue the expected result word
    function void note_word(logic op, logic [7:0] data);
      hssd_result_t r;
      int unsigned  idx;
      logic         taken;
      taken = 1'b0;
      if (op == OP_BYTE) begin
        if (data != CHAR_NUL) begin
          if (!have_first) begin
            first_char = data;
            have_first = 1'b1;
          end else begin
            have_first = 1'b0;
            run_command(first_char, data);
          end
        end
      end else if (active_period != '0) begin
        if (tick_count == active_period) begin
          tick_count   = '0;
          wrap_pending = 1'b1;
        end else begin
          tick_count = tick_count + 1'b1;
        end
      end
      if (enabled && wrap_pending) begin
        idx = step_idx;
        if (idx >= SEQ_LEN) idx = 0;
        coil = ccw ? CCW_PATTERN[idx] : CW_PATTERN[idx];
        idx++;
        step_idx     = (idx >= SEQ_LEN) ? 3'd0 : 3'(idx);
        wrap_pending = 1'b0;
        taken        = 1'b1;
      end
      r.coil_pattern = coil;
      r.step_taken   = taken;
      r.echo_valid   = (op == OP_BYTE);
      r.echo_byte    = (op == OP_BYTE) ? data : 8'h00;
      r.running      = enabled;
      expected_q.push_back(r);
    endfunction

    function void field_check(string name, int unsigned exp, int unsigned act);
      if (exp != act) begin
        $display("%0t: mismatch on %s: expected 0x%0h, actual 0x%0h", $time, name, exp, act);
        errors++;
      end
    endfunction

    function void check_result(hssd_result_t got);
      hssd_result_t exp;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result word: expected none, actual 0x%0h", $time, got);
        errors++;
        return;
      end
      exp = expected_q.pop_front();
      field_check("coil_pattern", exp.coil_pattern, got.coil_pattern);
      field_check("step_taken", exp.step_taken, got.step_taken);
      field_check("echo_valid", exp.echo_valid, got.echo_valid);
      field_check("echo_byte", exp.echo_byte, got.echo_byte);
      field_check("running", exp.running, got.running);
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic                   clk_i = 1'b0;
  logic                   rst_ni;
  logic                   in_valid_i;
  logic                   in_ready_o;
  logic                   operation_i;
  logic [7:0]             rx_byte_i;
  logic                   cfg_valid_i;
  logic                   cfg_ready_o;
  logic [CFG_INDEX_W-1:0] cfg_index_i;
  logic [PERIOD_W-1:0]    cfg_data_i;
  logic                   out_valid_o;
  logic                   out_ready_i;
  logic [COIL_W-1:0]      coil_pattern_o;
  logic                   step_taken_o;
  logic                   echo_valid_o;
  logic [7:0]             echo_byte_o;
  logic                   running_o;

  stepper_scoreboard sb;
  int                words_taken  = 0;
  int                regs_written = 0;
  bit                hold_req     = 1'b0;
  int                hold_count   = 0;
  rx_mode_e          rx_mode      = RX_ALWAYS;
  int                mode_left    = 0;
  int unsigned       rx_cycle     = 0;
  stim_word_t        backlog [$];

  half_step_stepper_command_driver #(
    .SEQUENCE_LENGTH(SEQ_LEN)
  ) u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .operation_i    (operation_i),
    .rx_byte_i      (rx_byte_i),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .coil_pattern_o (coil_pattern_o),
    .step_taken_o   (step_taken_o),
    .echo_valid_o   (echo_valid_o),
    .echo_byte_o    (echo_byte_o),
    .running_o      (running_o)
  );

  // 8 ns clock
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Handshake monitor: check results, then log accepted input and config words
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i)
        sb.check_result({coil_pattern_o, step_taken_o, echo_valid_o, echo_byte_o, running_o});
      if (in_valid_i && in_ready_o) begin
        sb.note_word(operation_i, rx_byte_i);
        words_taken++;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        sb.write_reg(cfg_index_i, cfg_data_i);
        regs_written++;
      end
    end
  end

  // Receiver: random stall modes, plus a long hold-off on request
  always @(negedge clk_i) begin
    rx_cycle++;
    if (hold_req) begin
      out_ready_i = 1'b0;
      hold_count++;
      if (hold_count >= HOLD_CYCLES) begin
        hold_req   = 1'b0;
        hold_count = 0;
      end
    end else begin
      if (mode_left == 0) begin
        rx_mode   = rx_mode_e'($urandom_range(RX_ALWAYS, RX_PERIODIC));
        mode_left = $urandom_range(16, 160);
      end
      mode_left--;
      case (rx_mode)
        RX_ALWAYS:   out_ready_i = 1'b1;
        RX_HALF:     out_ready_i = 1'($urandom_range(0, 1));
        RX_MOSTLY:   out_ready_i = ($urandom_range(0, 7) != 0);
        RX_SPARSE:   out_ready_i = ($urandom_range(0, 3) == 0);
        default:     out_ready_i = (rx_cycle % 3 != 0);
      endcase
    end
  end

  // Offer one input word and hold it until accepted; returns at a falling edge
  task automatic send_word(input logic op, input logic [7:0] data);
    int target;
    target      = words_taken + 1;
    in_valid_i  = 1'b1;
    operation_i = op;
    rx_byte_i   = data;
    do @(negedge clk_i); while (words_taken < target);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [PERIOD_W-1:0] data);
    int target;
    target      = regs_written + 1;
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = data;
    do @(negedge clk_i); while (regs_written < target);
    cfg_valid_i = 1'b0;
  endtask

  // Stop offering and wait until every expected result word is out
  task automatic drain();
    in_valid_i = 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
  endtask

  // Load all four speed registers for a phase, plus a write to a dead index
  task automatic load_speeds(input int kind);
    logic [PERIOD_W-1:0] p [NUM_SPEEDS];
    for (int i = 0; i < NUM_SPEEDS; i++) begin
      case (kind)
        0:       p[i] = 16'($urandom_range(0, 4));
        1:       p[i] = (i == 0) ? 16'h0000 : (i == 1) ? 16'hFFFF :
                        16'($urandom_range(1, 6));
        2:       p[i] = 16'($urandom_range(1, 9));
        3:       p[i] = ($urandom_range(0, 3) == 0) ? 16'($urandom) :
                        16'($urandom_range(0, 3));
        4:       p[i] = 16'($urandom_range(0, 2));
        default: p[i] = (i % 2 == 0) ? 16'hFFFF : 16'($urandom_range(0, 1));
      endcase
      write_reg(hssd_reg_e'(i), p[i]);
    end
    write_reg(REG_SPEED_THREE + CFG_INDEX_W'($urandom_range(1, 12)), 16'($urandom));
  endtask

  // Refill the stimulus backlog: mostly ticks and well-formed command pairs
  task automatic queue_token();
    int         r;
    logic [7:0] c;
    r = $urandom_range(0, 99);
    if (r < 45) begin
      backlog.push_back({OP_TICK, 8'($urandom)});
    end else if (r < 75) begin
      r = $urandom_range(0, 99);
      if (r < 35)      c = CHAR_CW;
      else if (r < 65) c = CHAR_CCW;
      else if (r < 85) c = CHAR_STOP;
      else begin
        do c = 8'($urandom_range(1, 255));
        while (c == CHAR_CW || c == CHAR_CCW || c == CHAR_STOP);
      end
      backlog.push_back({OP_BYTE, c});
      if ($urandom_range(0, 4) != 0) c = CHAR_DIGIT0 + 8'($urandom_range(0, 3));
      else                           c = 8'($urandom_range(0, 255));
      backlog.push_back({OP_BYTE, c});
    end else if (r < 83) begin
      backlog.push_back({OP_BYTE, CHAR_NUL});
    end else begin
      backlog.push_back({OP_BYTE, 8'($urandom_range(0, 255))});
    end
  endtask

  // Random traffic in bursts with gaps; optional long receiver hold-off
  task automatic run_phase(input int n_words, input bit with_hold);
    int         sent;
    int         burst;
    int         gap;
    stim_word_t w;
    sent = 0;
    while (sent < n_words) begin
      burst = $urandom_range(1, 24);
      gap   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      for (int k = 0; k < burst && sent < n_words; k++) begin
        if (backlog.size() == 0) queue_token();
        w = backlog.pop_front();
        send_word(w.op, w.data);
        sent++;
        if (with_hold && sent == n_words / 3) hold_req = 1'b1;
      end
      if (gap != 0) begin
        in_valid_i = 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
  endtask

  // Main sequence
  initial begin
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    operation_i = OP_BYTE;
    rx_byte_i   = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = REG_SPEED_ZERO;
    cfg_data_i  = '0;
    out_ready_i = 1'b0;
    sb          = new();
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // reset speed values first
    run_phase(100, 1'b0);

    // directed: short periods, dead index, every command and corner
    drain();
    write_reg(REG_SPEED_ZERO, 16'd1);
    write_reg(REG_SPEED_ONE, 16'd0);
    write_reg(REG_SPEED_TWO, 16'd3);
    write_reg(REG_SPEED_THREE, 16'hFFFF);
    write_reg(REG_SPEED_THREE + 1'b1, 16'h0000);
    send_word(OP_TICK, 8'hFF);           // counter halted
    send_word(OP_BYTE, CHAR_NUL);        // echoed, not paired
    send_word(OP_BYTE, CHAR_CW);
    send_word(OP_BYTE, CHAR_DIGIT0);     // clockwise, period 1
    repeat (4) send_word(OP_TICK, 8'h00);
    send_word(OP_BYTE, CHAR_STOP);
    send_word(OP_BYTE, CHAR_DIGIT0 + 8'd2); // stop ignores the digit
    repeat (2) send_word(OP_TICK, 8'h55); // wrap stays pending, coils hold
    send_word(OP_BYTE, CHAR_CCW);
    send_word(OP_BYTE, 8'h7A);           // non-digit: period kept, pending step fires
    send_word(OP_BYTE, 8'h51);
    send_word(OP_BYTE, CHAR_DIGIT0 + 8'd1); // other letter, period 0 halts
    send_word(OP_TICK, 8'hAA);
    send_word(OP_BYTE, CHAR_CCW);
    send_word(OP_BYTE, CHAR_DIGIT3);     // largest period
    send_word(OP_TICK, 8'h00);
    send_word(OP_BYTE, 8'hFF);
    send_word(OP_BYTE, CHAR_DIGIT0);
    repeat (2) send_word(OP_TICK, 8'h0F);
    send_word(OP_BYTE, CHAR_STOP);
    send_word(OP_BYTE, 8'h80);

    // random phases, each with its own speed setting
    for (int p = 0; p < 6; p++) begin
      drain();
      load_speeds(p);
      run_phase(255, p == 2);
    end

    drain();
    repeat (20) @(negedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

@@ half_step_stepper_command_driver.f @@
rtl/core/hssd_pkg.sv
rtl/core/hssd_cmd.sv
rtl/core/hssd_step.sv
rtl/core/hssd_outbuf.sv
rtl/core/half_step_stepper_command_driver.sv
sim/half_step_stepper_command_driver_tb.sv
